>>> src/mlfb_pkg.sv
// ----------------------------------------------------------------------------
// mlfb_pkg
// Types and constants shared by the frame buffer and line sender modules.
// ----------------------------------------------------------------------------
package mlfb_pkg;

   localparam int PanelWidth  = 176;
   localparam int PanelHeight = 176;
   localparam int RowBytes    = PanelWidth / 2;
   localparam int StoreDepth  = PanelWidth * PanelHeight / 2;
   localparam int AddrBits    = $clog2(StoreDepth);
   localparam int PacketBytes = RowBytes + 4;
   localparam int PosBits     = $clog2(PacketBytes);

   localparam logic [7:0] CMD_UPDATE  = 8'h90;
   localparam logic [7:0] CMD_CLEAR   = 8'h20;
   localparam logic [7:0] CMD_NONE    = 8'h00;
   localparam logic [7:0] CMD_WHITE   = 8'h18;
   localparam logic [7:0] CMD_BLACK   = 8'h10;
   localparam logic [7:0] CMD_INVERT  = 8'h14;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam logic [2:0] KIND_PIXEL = 3'd0;
   localparam logic [2:0] KIND_LINE  = 3'd1;
   localparam logic [2:0] KIND_CLEAR = 3'd2;
   localparam logic [2:0] KIND_BLINK = 3'd3;
   localparam logic [2:0] KIND_FRAME = 3'd4;

   localparam logic [2:0] BLINK_WHITE  = 3'd1;
   localparam logic [2:0] BLINK_BLACK  = 3'd2;
   localparam logic [2:0] BLINK_INVERT = 3'd3;

   localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
   localparam logic [2:0] REG_WIN_TOP    = 3'd1;
   localparam logic [2:0] REG_WIN_WIDTH  = 3'd2;
   localparam logic [2:0] REG_WIN_HEIGHT = 3'd3;
   localparam logic [2:0] REG_BACK_COLOR = 3'd4;
   localparam logic [2:0] REG_POLARITY   = 3'd5;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] pix_x;
      logic [7:0] pix_y;
      logic [3:0] pix_color;
      logic [7:0] row_index;
      logic [2:0] blink_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_hi;
      logic [7:0] byte_lo;
      logic [1:0] byte_count;
      logic       com_level;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] win_left;
      logic [7:0] win_top;
      logic [7:0] win_width;
      logic [7:0] win_height;
      logic [3:0] back_color;
      logic       cmd_polarity;
   } cfg_type;

endpackage

>>> src/mlfb_regs.sv
// ----------------------------------------------------------------------------
// mlfb_regs
// Configuration register file written through the csr channel.
// ----------------------------------------------------------------------------
module mlfb_regs import mlfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [2:0] wr_index,
   input  logic [7:0] wr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_WIN_LEFT:   cfg_in.win_left     = wr_data;
            REG_WIN_TOP:    cfg_in.win_top      = wr_data;
            REG_WIN_WIDTH:  cfg_in.win_width    = wr_data;
            REG_WIN_HEIGHT: cfg_in.win_height   = wr_data;
            REG_BACK_COLOR: cfg_in.back_color   = wr_data[3:0];
            REG_POLARITY:   cfg_in.cmd_polarity = wr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{win_left: 8'd0, win_top: 8'd0, win_width: 8'(PanelWidth),
                     win_height: 8'(PanelHeight), back_color: 4'd0, cmd_polarity: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/mlfb_engine.sv
// ----------------------------------------------------------------------------
// mlfb_engine
// Pixel buffer memory with its sequencer: pixel read-modify-write, fill
// sweep, line packet framing one byte read at a time, and single command beats.
// ----------------------------------------------------------------------------
module mlfb_engine import mlfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_take,
   input  req_type item,
   input  cfg_type cfg,
   input  logic    out_free,
   output logic    idle,
   output logic    push,
   output rsp_type word
);

   typedef enum logic [7:0] {
      S_SWEEP  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_PIXRD  = 8'b0000_0100,
      S_PIXWR  = 8'b0000_1000,
      S_LADDR  = 8'b0001_0000,
      S_LDATA  = 8'b0010_0000,
      S_LPUSH  = 8'b0100_0000,
      S_PUSH   = 8'b1000_0000
   } state_type;

   logic [7:0] mem [StoreDepth];
   logic [7:0] rdata_ff;
   logic [AddrBits-1:0] rd_addr;
   logic                we;
   logic [AddrBits-1:0] waddr;
   logic [7:0]          wdata;

   state_type state_ff, state_in;
   logic [AddrBits-1:0] addr_ff, addr_in;
   logic [7:0]          fill_ff, fill_in;
   logic                sweep_word_ff, sweep_word_in;
   logic                com_ff, com_in;
   logic                hi_nib_ff, hi_nib_in;
   logic [3:0]          color_ff, color_in;
   rsp_type             word_ff, word_in;
   logic [PosBits-1:0]  pos_ff, pos_in;
   logic [6:0]          copy_ff, copy_in;
   logic [6:0]          dst0_ff, dst0_in;
   logic [14:0]         base_ff, base_in;
   logic [7:0]          line_ff, line_in;
   logic [7:0]          const_ff, const_in;
   logic                use_mem_ff, use_mem_in;

   // Item decode.
   logic [8:0]  x_end, y_end, line_full;
   logic        in_win;
   logic [7:0]  dy, dx;
   logic [15:0] pix_idx;
   logic [7:0]  pol;
   logic [7:0]  back_pair;
   logic [7:0]  blink_code;
   logic [6:0]  copy_calc;
   logic [7:0]  edge_gap;
   logic        line_ok;

   // Line byte selection.
   logic [6:0]  d_off;
   logic [6:0]  j_off;
   logic [15:0] src;
   logic        in_copy;
   logic [7:0]  cur_byte;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      pol       = {1'b0, cfg.cmd_polarity, 6'd0};
      back_pair = {cfg.back_color, cfg.back_color};
      x_end     = {1'b0, cfg.win_left} + {1'b0, cfg.win_width};
      y_end     = {1'b0, cfg.win_top} + {1'b0, cfg.win_height};
      in_win    = (item.pix_x >= cfg.win_left) && ({1'b0, item.pix_x} < x_end) &&
                  (item.pix_y >= cfg.win_top) && ({1'b0, item.pix_y} < y_end);
      dy        = item.pix_y - cfg.win_top;
      dx        = item.pix_x - cfg.win_left;
      pix_idx   = 16'(cfg.win_width[7:1] * dy) + {9'd0, dx[7:1]};

      unique case (item.blink_mode)
         BLINK_WHITE:  blink_code = CMD_WHITE;
         BLINK_BLACK:  blink_code = CMD_BLACK;
         BLINK_INVERT: blink_code = CMD_INVERT;
         default:      blink_code = CMD_NONE;
      endcase

      edge_gap = 8'(PanelWidth) - cfg.win_left;
      if (x_end < 9'(PanelWidth)) begin
         copy_calc = cfg.win_width[7:1];
      end else if ({1'b0, cfg.win_left} < 9'(PanelWidth)) begin
         copy_calc = edge_gap[7:1];
      end else begin
         copy_calc = 7'd0;
      end
      line_full = {1'b0, cfg.win_top} + {1'b0, item.row_index};
      line_ok   = (item.row_index < cfg.win_height) && (line_full < 9'(PanelHeight));

      // Row byte for packet position pos_ff, row bytes start at position two.
      d_off   = 7'(pos_ff - PosBits'(2));
      j_off   = d_off - dst0_ff;
      src     = {1'b0, base_ff} + {9'd0, j_off};
      in_copy = (d_off >= dst0_ff) && (j_off < copy_ff) && (src < 16'(StoreDepth));
      cur_byte = use_mem_ff ? rdata_ff : const_ff;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      fill_in       = fill_ff;
      sweep_word_in = sweep_word_ff;
      com_in        = com_ff;
      hi_nib_in     = hi_nib_ff;
      color_in      = color_ff;
      word_in       = word_ff;
      pos_in        = pos_ff;
      copy_in       = copy_ff;
      dst0_in       = dst0_ff;
      base_in       = base_ff;
      line_in       = line_ff;
      const_in      = const_ff;
      use_mem_in    = use_mem_ff;
      rd_addr       = addr_ff;
      we            = 1'b0;
      waddr         = addr_ff;
      wdata         = fill_ff;
      push          = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            we = 1'b1;
            addr_in = addr_ff + AddrBits'(1);
            if (addr_ff == AddrBits'(StoreDepth - 1)) begin
               addr_in  = '0;
               state_in = sweep_word_ff ? S_PUSH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_take) begin
               unique case (item.kind)
                  KIND_PIXEL: begin
                     addr_in   = pix_idx[AddrBits-1:0];
                     hi_nib_in = ~item.pix_x[0];
                     color_in  = item.pix_color;
                     if (in_win && (pix_idx < 16'(StoreDepth))) begin
                        state_in = S_PIXRD;
                     end
                  end
                  KIND_LINE: begin
                     copy_in  = copy_calc;
                     dst0_in  = cfg.win_left[7:1];
                     base_in  = 15'(cfg.win_width[7:1] * item.row_index);
                     line_in  = line_full[7:0] + 8'd1;
                     const_in = CMD_UPDATE | pol;
                     pos_in   = '0;
                     if (line_ok) begin
                        state_in = S_LADDR;
                     end
                  end
                  KIND_CLEAR: begin
                     com_in        = ~com_ff;
                     fill_in       = back_pair;
                     addr_in       = '0;
                     sweep_word_in = 1'b1;
                     word_in       = '{byte_hi: CMD_CLEAR | pol, byte_lo: 8'd0,
                                       byte_count: 2'd2, com_level: ~com_ff, last: 1'b1};
                     state_in      = S_SWEEP;
                  end
                  KIND_BLINK: begin
                     word_in  = '{byte_hi: blink_code | pol, byte_lo: 8'd0,
                                  byte_count: 2'd2, com_level: com_ff, last: 1'b1};
                     state_in = S_PUSH;
                  end
                  KIND_FRAME: begin
                     com_in   = ~com_ff;
                     word_in  = '{byte_hi: 8'd0, byte_lo: 8'd0, byte_count: 2'd0,
                                  com_level: ~com_ff, last: 1'b0};
                     state_in = S_PUSH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PIXRD: begin
            state_in = S_PIXWR;
         end
         S_PIXWR: begin
            we       = 1'b1;
            wdata    = hi_nib_ff ? {color_ff, rdata_ff[3:0]} : {rdata_ff[7:4], color_ff};
            state_in = S_IDLE;
         end
         S_LADDR: begin
            // Pick the source of the byte at pos_ff; a buffer read returns next cycle.
            rd_addr    = src[AddrBits-1:0];
            use_mem_in = 1'b0;
            if (pos_ff == '0) begin
               const_in = CMD_UPDATE | pol;
            end else if (pos_ff == PosBits'(1)) begin
               const_in = line_ff;
            end else if (pos_ff >= PosBits'(RowBytes + 2)) begin
               const_in = 8'd0;
            end else begin
               const_in   = back_pair;
               use_mem_in = in_copy;
            end
            state_in = S_LDATA;
         end
         S_LDATA: begin
            if (!pos_ff[0]) begin
               word_in.byte_hi = cur_byte;
               pos_in   = pos_ff + PosBits'(1);
               state_in = S_LADDR;
            end else begin
               word_in = '{byte_hi: word_ff.byte_hi, byte_lo: cur_byte, byte_count: 2'd2,
                           com_level: com_ff,
                           last: (pos_ff == PosBits'(PacketBytes - 1))};
               state_in = S_LPUSH;
            end
         end
         S_LPUSH: begin
            if (out_free) begin
               push = 1'b1;
               if (word_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + PosBits'(1);
                  state_in = S_LADDR;
               end
            end
         end
         S_PUSH: begin
            if (out_free) begin
               push          = 1'b1;
               sweep_word_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         addr_ff       <= '0;
         fill_ff       <= 8'd0;
         sweep_word_ff <= 1'b0;
         com_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         fill_ff       <= fill_in;
         sweep_word_ff <= sweep_word_in;
         com_ff        <= com_in;
      end
      hi_nib_ff  <= hi_nib_in;
      color_ff   <= color_in;
      word_ff    <= word_in;
      pos_ff     <= pos_in;
      copy_ff    <= copy_in;
      dst0_ff    <= dst0_in;
      base_ff    <= base_in;
      line_ff    <= line_in;
      const_ff   <= const_in;
      use_mem_ff <= use_mem_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign word = word_ff;

endmodule

>>> src/memory_lcd_frame_buffer_and_line_sender_unit.sv
// ----------------------------------------------------------------------------
// memory_lcd_frame_buffer_and_line_sender_unit
// Frame buffer of 4-bit pixels behind a color memory LCD packet framer.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (valid/stall) and packet words leave on the
// rsp_ channel (valid/stall), each beat carrying up to two bytes. Registers
// are written on the csr_ channel, which is always ready.
// The block works on one item at a time; req_stall is high while an item is
// in progress. A pixel write reads the buffer byte and then writes it back
// with one nibble replaced. A line send reads the buffer one byte at a time
// over its single read port and then hands each of its 46 beats to the
// output register, waiting while that register is full and stalled.
// Blink and frame end send a single beat. An all-clear sweeps the whole
// buffer, one byte per cycle, and then sends its clear beat.
// After reset the buffer is swept to zero before the first item is taken;
// csr writes are taken during the sweep.
// Results pass through one output register; while rsp_stall is high the beat
// holds and the sequencer waits, but the next item can be accepted once the
// last beat of the current one sits in the output register.
// ----------------------------------------------------------------------------
module memory_lcd_frame_buffer_and_line_sender_unit import mlfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type cfg;
   logic    idle;
   logic    push;
   logic    out_free;
   rsp_type word;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   mlfb_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign req_stall = ~idle;
   assign out_free  = ~rsp_valid_ff || ~rsp_stall;

   mlfb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .item_take (req_valid && ~req_stall),
      .item      (req_data),
      .cfg       (cfg),
      .out_free  (out_free),
      .idle      (idle),
      .push      (push),
      .word      (word)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/mlfb_line_checker.sv
// ----------------------------------------------------------------------------
// mlfb_line_checker
// Watches the item, register and packet channels of the frame buffer and line
// sender, keeps its own copy of the pixel store and settings, works out the
// packet words each accepted item must produce and compares every word beat.
// ----------------------------------------------------------------------------
module mlfb_line_checker import mlfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   output int         words_pending,
   output int         mismatches
);

   logic [7:0] frame_mem [StoreDepth];
   cfg_type    regs;
   logic       com_bit;
   rsp_type    word_q [$];
   int         err_cnt;

   // Cuts a byte stream into word beats of up to two bytes.
   function automatic void queue_packet(logic [7:0] pkt [PacketBytes], int n);
      rsp_type w;
      for (int i = 0; i < n; i += 2) begin
         w.byte_hi    = pkt[i];
         w.byte_lo    = (n - i >= 2) ? pkt[i + 1] : 8'h00;
         w.byte_count = (n - i >= 2) ? 2'd2 : 2'd1;
         w.com_level  = com_bit;
         w.last       = (i + 2 >= n);
         word_q.push_back(w);
      end
   endfunction

   function automatic void predict_item(req_type r);
      int unsigned left, top, wid, hgt, idx, line, copy, dst0, base;
      logic [7:0]  pkt [PacketBytes];
      logic [7:0]  pol, pair, cmd;
      rsp_type     w;
      left = regs.win_left;
      top  = regs.win_top;
      wid  = regs.win_width;
      hgt  = regs.win_height;
      pol  = {1'b0, regs.cmd_polarity, 6'b0};
      pair = {regs.back_color, regs.back_color};
      case (r.kind)
         KIND_PIXEL: begin
            if (r.pix_x >= left && r.pix_x < left + wid &&
                r.pix_y >= top && r.pix_y < top + hgt) begin
               idx = (wid / 2) * (r.pix_y - top) + (r.pix_x - left) / 2;
               if (idx < StoreDepth) begin
                  if (r.pix_x[0] == 1'b0)
                     frame_mem[idx][7:4] = r.pix_color;
                  else
                     frame_mem[idx][3:0] = r.pix_color;
               end
            end
         end
         KIND_LINE: begin
            line = top + r.row_index;
            if (r.row_index < hgt && line < PanelHeight) begin
               if (left + wid < PanelWidth)
                  copy = wid / 2;
               else if (left < PanelWidth)
                  copy = (PanelWidth - left) / 2;
               else
                  copy = 0;
               pkt[0] = CMD_UPDATE | pol;
               pkt[1] = 8'(line + 1);
               for (int j = 0; j < RowBytes; j++)
                  pkt[2 + j] = pair;
               dst0 = left / 2;
               base = (wid / 2) * r.row_index;
               for (int unsigned j = 0; j < copy; j++) begin
                  if (dst0 + j >= RowBytes)
                     break;
                  if (base + j < StoreDepth)
                     pkt[2 + dst0 + j] = frame_mem[base + j];
               end
               pkt[2 + RowBytes] = 8'h00;
               pkt[3 + RowBytes] = 8'h00;
               queue_packet(pkt, PacketBytes);
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < StoreDepth; i++)
               frame_mem[i] = pair;
            com_bit = ~com_bit;
            pkt[0] = CMD_CLEAR | pol;
            pkt[1] = 8'h00;
            queue_packet(pkt, 2);
         end
         KIND_BLINK: begin
            case (r.blink_mode)
               BLINK_WHITE:  cmd = CMD_WHITE;
               BLINK_BLACK:  cmd = CMD_BLACK;
               BLINK_INVERT: cmd = CMD_INVERT;
               default:      cmd = CMD_NONE;
            endcase
            pkt[0] = cmd | pol;
            pkt[1] = 8'h00;
            queue_packet(pkt, 2);
         end
         KIND_FRAME: begin
            com_bit = ~com_bit;
            w = '0;
            w.com_level = com_bit;
            word_q.push_back(w);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < StoreDepth; i++)
            frame_mem[i] = 8'h00;
         regs    = '{win_left: 8'd0, win_top: 8'd0, win_width: 8'd176,
                     win_height: 8'd176, back_color: 4'd0, cmd_polarity: 1'b0};
         com_bit = 1'b0;
         word_q.delete();
         err_cnt = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIN_LEFT:   regs.win_left     = csr_data;
               REG_WIN_TOP:    regs.win_top      = csr_data;
               REG_WIN_WIDTH:  regs.win_width    = csr_data;
               REG_WIN_HEIGHT: regs.win_height   = csr_data;
               REG_BACK_COLOR: regs.back_color   = csr_data[3:0];
               REG_POLARITY:   regs.cmd_polarity = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (word_q.size() == 0) begin
               $error("packet beat with no word expected: %h", rsp_data);
               err_cnt++;
            end else begin
               want = word_q.pop_front();
               if (rsp_data.byte_hi !== want.byte_hi) begin
                  $error("byte_hi: expected %h, actual %h", want.byte_hi, rsp_data.byte_hi);
                  err_cnt++;
               end
               if (rsp_data.byte_lo !== want.byte_lo) begin
                  $error("byte_lo: expected %h, actual %h", want.byte_lo, rsp_data.byte_lo);
                  err_cnt++;
               end
               if (rsp_data.byte_count !== want.byte_count) begin
                  $error("byte_count: expected %0d, actual %0d", want.byte_count,
                         rsp_data.byte_count);
                  err_cnt++;
               end
               if (rsp_data.com_level !== want.com_level) begin
                  $error("com_level: expected %b, actual %b", want.com_level,
                         rsp_data.com_level);
                  err_cnt++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %b, actual %b", want.last, rsp_data.last);
                  err_cnt++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_item(req_data);
      end
      words_pending <= word_q.size();
      mismatches    <= err_cnt;
   end

endmodule

>>> tb/tb_memory_lcd_frame_buffer_and_line_sender_unit.sv
// ----------------------------------------------------------------------------
// tb_memory_lcd_frame_buffer_and_line_sender_unit
// Drives pixel writes, line sends, clears, blink commands and frame ends
// through a series of window and color settings, with random gaps and stalls
// on both channels; the line checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_memory_lcd_frame_buffer_and_line_sender_unit;
   import mlfb_pkg::*;

   localparam int CycleLimit = 1500000;
   localparam int NumSetups  = 7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   int         words_pending;
   int         mismatches;
   int         gap_pct = 10;
   int         items_sent = 0;
   int         cycle_cnt = 0;
   logic       hold_rsp = 1'b0;
   cfg_type    setups [NumSetups];

   always #5 clock = ~clock;

   memory_lcd_frame_buffer_and_line_sender_unit i_dut (.*);

   mlfb_line_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && (hold_rsp || $urandom_range(99) < gap_pct);

   // Long receiver hold-off while items keep coming, so the block backs up.
   initial begin
      while (items_sent < 120)
         @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (600) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic send_item(req_type r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Lets every expected word drain, then gives a pixel write time to land.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type make_item(int kind);
      req_type r;
      r.kind       = 3'(kind);
      r.pix_x      = 8'($urandom_range(255));
      r.pix_y      = 8'($urandom_range(255));
      r.pix_color  = 4'($urandom_range(15));
      r.row_index  = 8'($urandom_range(255));
      r.blink_mode = 3'($urandom_range(7));
      return r;
   endfunction

   function automatic req_type random_item(cfg_type c);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         r = make_item(KIND_PIXEL);
         if (c.win_width != 0)
            r.pix_x = 8'(c.win_left + $urandom_range(c.win_width - 1));
         if (c.win_height != 0)
            r.pix_y = 8'(c.win_top + $urandom_range(c.win_height - 1));
      end else if (pick < 55) begin
         r = make_item(KIND_PIXEL);
      end else if (pick < 83) begin
         r = make_item(KIND_LINE);
         if (c.win_height != 0 && $urandom_range(9) != 0)
            r.row_index = 8'($urandom_range(c.win_height - 1));
      end else if (pick < 84) begin
         r = make_item(KIND_CLEAR);
      end else if (pick < 90) begin
         r = make_item(KIND_BLINK);
      end else if (pick < 96) begin
         r = make_item(KIND_FRAME);
      end else begin
         r = make_item($urandom_range(7, 5));
      end
      return r;
   endfunction

   initial begin
      req_type r;
      cfg_type c;
      setups[0] = '{8'd0,   8'd0,   8'd176, 8'd176, 4'd0,  1'b0};
      setups[1] = '{8'd10,  8'd20,  8'd60,  8'd40,  4'd5,  1'b1};
      setups[2] = '{8'd175, 8'd175, 8'd176, 8'd176, 4'd15, 1'b0};
      setups[3] = '{8'd120, 8'd8,   8'd100, 8'd30,  4'd9,  1'b1};
      setups[4] = '{8'd0,   8'd0,   8'd0,   8'd0,   4'd3,  1'b0};
      setups[5] = '{8'd33,  8'd100, 8'd77,  8'd90,  4'd12, 1'b1};
      setups[6] = '{8'd0,   8'd0,   8'd176, 8'd176, 4'd15, 1'b1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int s = 0; s < NumSetups; s++) begin
         c = setups[s];
         write_reg(REG_WIN_LEFT,   c.win_left);
         write_reg(REG_WIN_TOP,    c.win_top);
         write_reg(REG_WIN_WIDTH,  c.win_width);
         write_reg(REG_WIN_HEIGHT, c.win_height);
         write_reg(REG_BACK_COLOR, {4'd0, c.back_color});
         write_reg(REG_POLARITY,   {7'd0, c.cmd_polarity});
         if (s == 0) begin
            // Two opposite corners of the panel, an out-of-range pixel, edge rows and
            // every command kind, including the unused ones.
            r = '0; r.kind = KIND_PIXEL; r.pix_color = 4'hF;
            send_item(r);
            r.pix_x = 8'd1; r.pix_color = 4'h5;
            send_item(r);
            r.pix_x = 8'd175; r.pix_y = 8'd175; r.pix_color = 4'hA;
            send_item(r);
            r.pix_x = 8'd255; r.pix_y = 8'd255; r.pix_color = 4'h3;
            send_item(r);
            r = '0; r.kind = KIND_LINE;
            send_item(r);
            r.row_index = 8'd175;
            send_item(r);
            r.row_index = 8'd255;
            send_item(r);
            r = '0; r.kind = KIND_BLINK;
            for (int m = 0; m < 8; m++) begin
               r.blink_mode = 3'(m);
               send_item(r);
            end
            r = '0; r.kind = KIND_FRAME;
            send_item(r);
            r.kind = KIND_CLEAR;
            send_item(r);
            r.kind = KIND_LINE;
            send_item(r);
            for (int k = 5; k < 8; k++) begin
               r = '1; r.kind = 3'(k);
               send_item(r);
            end
         end
         // One setup runs with no gaps or stalls at all.
         gap_pct = (s == 3) ? 0 : 10;
         for (int n = 0; n < 52; n++)
            send_item(random_item(c));
         drain();
      end
      gap_pct = 10;
      repeat (50) @(posedge clock);
      if (mismatches == 0 && words_pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
